[rtl/text_mode_terminal_writer_macros.svh]
// Assertion macros for the text mode terminal writer checker.
// Included by tmtw_checker.sv; no other dependencies.
`ifndef TEXT_MODE_TERMINAL_WRITER_MACROS_SVH
`define TEXT_MODE_TERMINAL_WRITER_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define TMTW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define TMTW_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/tmtw_pkg.sv]
// Shared constants and types for the text mode terminal writer.
// No dependencies; imported by the top level and its checker.
package tmtw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int ADDR_W  = 11;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CHAR_W  = 8;
    localparam int CELL_W  = 16;

    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'd32;
    localparam logic [CHAR_W-1:0] COLOR_RESET    = 8'h0F;
    localparam logic [CELL_W-1:0] RESET_CELL     = 16'h0F20;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Output tdata bit positions
    localparam int OUT_ROW_LSB = CELL_W;
    localparam int OUT_COL_LSB = OUT_ROW_LSB + ROW_W;
    localparam int OUT_SCR_BIT = OUT_COL_LSB + COL_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PUT,
        ST_SC_COPY,
        ST_SC_BLANK,
        ST_FINISH
    } t_state;

endpackage

[rtl/text_mode_terminal_writer.sv]
// Top level of the text mode terminal writer: sequencer, cursor and cell RAM.
// Depends on tmtw_pkg.
//
// Teletype over an 80x25 store of 16-bit cells (char low byte, attribute high
// byte). After reset the block clears all 2000 cells of the RAM to white
// spaces, one cell a cycle, with s_axis_tready low; config writes are taken.
// A request occupies the block from acceptance until its result is loaded into
// the output register: a read goes to ST_FINISH (RAM read at acceptance), a
// put passes ST_PUT first, and a scrolling put adds ST_SC_COPY and ST_SC_BLANK,
// where the single RAM read port and write port move one cell per cycle for
// the 1920-cell copy and then blank the 80 bottom cells. A new request can be
// accepted while the previous result waits in the output register. text_color
// may be written any time the block holds no pending request.
module text_mode_terminal_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // char_code[7:0], read_address[18:8], zero
    input  logic        i_s_axis_tuser,   // op: 0 put, 1 read
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // cell_data[15:0], cursor_row[20:16],
                                          // cursor_column[27:21], scrolled[28], zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data        // text_color
);
    import tmtw_pkg::*;

    t_state r_state, n_state;

    logic [ADDR_W-1:0] r_idx, n_idx;
    logic              r_wr_pend, n_wr_pend;
    logic [ADDR_W-1:0] r_wr_addr, n_wr_addr;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [CHAR_W-1:0] r_color;
    logic              r_op, n_op;
    logic [CHAR_W-1:0] r_char, n_char;
    logic              r_rd_ok, n_rd_ok;
    logic              r_scrolled, n_scrolled;

    logic              r_out_valid, n_out_valid;
    logic [CELL_W-1:0] r_out_cell, n_out_cell;
    logic [ROW_W-1:0]  r_out_row, n_out_row;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic              r_out_scr, n_out_scr;

    // Cell RAM
    logic [CELL_W-1:0] r_mem [0:CELLS-1];
    logic [CELL_W-1:0] r_rdata;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata;

    logic [ADDR_W-1:0] in_addr;
    logic [CHAR_W-1:0] in_char;
    logic [ADDR_W-1:0] cur_lin;
    logic [ROW_W-1:0]  put_row;
    logic [COL_W-1:0]  put_col;

    assign in_char = i_s_axis_tdata[7:0];
    assign in_addr = i_s_axis_tdata[18:8];
    assign cur_lin = ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_col);

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_scr, r_out_col, r_out_row, r_out_cell};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_idx       <= '0;
            r_wr_pend   <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_color     <= COLOR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_wr_pend   <= n_wr_pend;
            r_row       <= n_row;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_color <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr  <= n_wr_addr;
        r_op       <= n_op;
        r_char     <= n_char;
        r_rd_ok    <= n_rd_ok;
        r_scrolled <= n_scrolled;
        r_out_cell <= n_out_cell;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_scr  <= n_out_scr;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_wr_pend   = r_wr_pend;
        n_wr_addr   = r_wr_addr;
        n_row       = r_row;
        n_col       = r_col;
        n_op        = r_op;
        n_char      = r_char;
        n_rd_ok     = r_rd_ok;
        n_scrolled  = r_scrolled;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_cell  = r_out_cell;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_scr   = r_out_scr;
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = RESET_CELL;
        mem_re      = 1'b0;
        mem_raddr   = in_addr;
        put_row     = r_row;
        put_col     = r_col;

        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (r_idx == ADDR_W'(CELLS - 1)) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_op       = i_s_axis_tuser;
                    n_char     = in_char;
                    n_scrolled = 1'b0;
                    n_rd_ok    = in_addr < ADDR_W'(CELLS);
                    if (i_s_axis_tuser == OP_READ) begin
                        mem_re  = n_rd_ok;
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_PUT;
                    end
                end
            end

            ST_PUT: begin
                mem_wdata = {r_color, CODE_SPACE};
                if (r_char == CODE_NEWLINE) begin
                    put_col = '0;
                    put_row = r_row + 1'b1;
                end else if (r_char == CODE_BACKSPACE) begin
                    // step back one cell, wrapping to the row above; no-op at origin
                    mem_waddr = cur_lin - 1'b1;
                    if (r_col != '0) begin
                        mem_we  = 1'b1;
                        put_col = r_col - 1'b1;
                    end else if (r_row != '0) begin
                        mem_we  = 1'b1;
                        put_row = r_row - 1'b1;
                        put_col = COL_W'(COLUMNS - 1);
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = cur_lin;
                    mem_wdata = {r_color, r_char};
                    if (r_col == COL_W'(COLUMNS - 1)) begin
                        put_col = '0;
                        put_row = r_row + 1'b1;
                    end else begin
                        put_col = r_col + 1'b1;
                    end
                end
                if (put_row == ROW_W'(ROWS)) begin
                    n_row      = ROW_W'(ROWS - 1);
                    n_col      = '0;
                    n_scrolled = 1'b1;
                    n_idx      = '0;
                    n_wr_pend  = 1'b0;
                    n_state    = ST_SC_COPY;
                end else begin
                    n_row   = put_row;
                    n_col   = put_col;
                    n_state = ST_FINISH;
                end
            end

            ST_SC_COPY: begin
                // read cell one row down, write last cycle's read one row up
                mem_re    = 1'b1;
                mem_raddr = r_idx + ADDR_W'(COLUMNS);
                mem_we    = r_wr_pend;
                mem_waddr = r_wr_addr;
                mem_wdata = {r_color, r_rdata[7:0]};
                n_wr_pend = 1'b1;
                n_wr_addr = r_idx;
                if (r_idx == ADDR_W'(CELLS - COLUMNS - 1)) begin
                    n_idx   = ADDR_W'(CELLS - COLUMNS);
                    n_state = ST_SC_BLANK;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            ST_SC_BLANK: begin
                mem_we = 1'b1;
                if (r_wr_pend) begin
                    mem_waddr = r_wr_addr;
                    mem_wdata = {r_color, r_rdata[7:0]};
                    n_wr_pend = 1'b0;
                end else begin
                    mem_waddr = r_idx;
                    mem_wdata = {r_color, CODE_SPACE};
                    if (r_idx == ADDR_W'(CELLS - 1)) begin
                        n_idx   = '0;
                        n_state = ST_FINISH;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end

            ST_FINISH: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_cell  = (r_op == OP_READ && r_rd_ok) ? r_rdata : '0;
                    n_out_row   = r_row;
                    n_out_col   = r_col;
                    n_out_scr   = r_scrolled;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/tmtw_checker.sv]
// Port-level checker for the text mode terminal writer, bound to the top level.
// Depends on tmtw_pkg and text_mode_terminal_writer_macros.svh.
`include "text_mode_terminal_writer_macros.svh"

module tmtw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [23:0] i_s_axis_tdata,
    input logic        i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [7:0]  i_cfg_data
);
    import tmtw_pkg::*;

    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             out_scr;

    assign out_row = o_m_axis_tdata[OUT_COL_LSB-1:OUT_ROW_LSB];
    assign out_col = o_m_axis_tdata[OUT_SCR_BIT-1:OUT_COL_LSB];
    assign out_scr = o_m_axis_tdata[OUT_SCR_BIT];

    `TMTW_ASSERT(a_row_range, o_m_axis_tvalid |-> out_row < ROW_W'(ROWS), "cursor row out of range")
    `TMTW_ASSERT(a_col_range, o_m_axis_tvalid |-> out_col < COL_W'(COLUMNS), "cursor column out of range")
    `TMTW_ASSERT(a_scroll_home, (o_m_axis_tvalid && out_scr) |-> (out_row == ROW_W'(ROWS - 1) && out_col == '0), "scroll did not leave cursor at start of last row")
    `TMTW_ASSERT_ALWAYS(a_out_hold, (i_rst_n && $past(i_rst_n) && $past(o_m_axis_tvalid && !i_m_axis_tready)) |-> (o_m_axis_tvalid && $stable(o_m_axis_tdata)), "stalled result changed")

endmodule

bind text_mode_terminal_writer tmtw_checker u_tmtw_checker (.*);

[sim/text_mode_terminal_writer_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for text_mode_terminal_writer: puts, reads, wraps, scrolls.
// Depends on tmtw_pkg and the RTL; the expected results come from an in-bench terminal model.
module text_mode_terminal_writer_tb;
    import tmtw_pkg::*;

    localparam int WATCHDOG_LIMIT = 12000;
    localparam int MAX_REPORTS    = 10;
    localparam int ITEMS_PER_PASS = 215;

    typedef struct packed {
        logic [CELL_W-1:0] cell_data;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  column;
        logic              scrolled;
    } t_tty_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata;   // char_code[7:0], read_address[18:8], zero
    logic        i_s_axis_tuser;   // op: 0 put, 1 read
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;   // cell_data[15:0], cursor_row[20:16],
                                   // cursor_column[27:21], scrolled[28], zero
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;       // text_color

    // terminal model state
    logic [CELL_W-1:0] screen_cells [0:CELLS-1];
    int                cur_row;
    int                cur_col;
    logic [CHAR_W-1:0] text_color;

    t_tty_result awaited_reports [$];
    t_tty_result seen_report;
    t_tty_result want_report;
    int          mismatch_count;
    int          idle_cycles;
    bit          sender_gaps;
    bit          receiver_stalls;

    text_mode_terminal_writer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Updates the terminal model with one accepted request and returns its report.
    function automatic t_tty_result advance_terminal(logic op, logic [CHAR_W-1:0] ch,
                                                     logic [ADDR_W-1:0] addr);
        t_tty_result r;
        int          i;
        r = '0;
        if (op == OP_READ) begin
            if (addr < CELLS)
                r.cell_data = screen_cells[addr];
        end else if (ch == CODE_NEWLINE) begin
            cur_col = 0;
            cur_row++;
        end else if (ch == CODE_BACKSPACE) begin
            if (cur_col != 0) begin
                cur_col--;
                screen_cells[cur_row*COLUMNS + cur_col] = {text_color, CODE_SPACE};
            end else if (cur_row != 0) begin
                cur_row--;
                cur_col = COLUMNS - 1;
                screen_cells[cur_row*COLUMNS + cur_col] = {text_color, CODE_SPACE};
            end
        end else begin
            screen_cells[cur_row*COLUMNS + cur_col] = {text_color, ch};
            cur_col++;
            if (cur_col >= COLUMNS) begin
                cur_col = 0;
                cur_row++;
            end
        end
        // scroll keeps characters but recolors every cell
        if (op == OP_PUT && cur_row >= ROWS) begin
            for (i = 0; i < CELLS - COLUMNS; i++)
                screen_cells[i] = {text_color, screen_cells[i + COLUMNS][CHAR_W-1:0]};
            for (i = CELLS - COLUMNS; i < CELLS; i++)
                screen_cells[i] = {text_color, CODE_SPACE};
            cur_row    = ROWS - 1;
            cur_col    = 0;
            r.scrolled = 1'b1;
        end
        r.row    = cur_row[ROW_W-1:0];
        r.column = cur_col[COL_W-1:0];
        return r;
    endfunction

    // Leaves tvalid high after the handshake so back-to-back requests need no re-raise.
    task automatic send_request(logic op, logic [CHAR_W-1:0] ch, logic [ADDR_W-1:0] addr);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {5'b0, addr, ch};
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
        awaited_reports.push_back(advance_terminal(op, ch, addr));
    endtask

    task automatic put_char(logic [CHAR_W-1:0] ch);
        send_request(OP_PUT, ch, ADDR_W'($urandom_range(0, 2047)));
    endtask

    task automatic read_cell(int addr);
        send_request(OP_READ, CHAR_W'($urandom_range(0, 255)), ADDR_W'(addr));
    endtask

    task automatic drain;
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (awaited_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_color(logic [CHAR_W-1:0] color);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= color;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        text_color = color;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Reset contents, reset color, out-of-range reads, backspace at the origin.
    task automatic test_reset_state;
        read_cell(0);
        read_cell(CELLS - 1);
        read_cell(CELLS);
        read_cell(2047);
        put_char(CODE_BACKSPACE);
        put_char(8'h41);
        read_cell(0);
        drain();
    endtask

    // Extreme characters, newline, backspace wrapping to the previous row.
    task automatic test_control_codes;
        put_char(8'h00);
        put_char(8'hFF);
        put_char(CODE_NEWLINE);
        put_char(CODE_BACKSPACE);
        read_cell(COLUMNS - 1);
        put_char(8'h7F);          // last column: wraps to next row
        read_cell(COLUMNS - 1);
        put_char(CODE_BACKSPACE);
        put_char(CODE_BACKSPACE);
        put_char(CODE_NEWLINE);
        read_cell(COLUMNS - 2);
        read_cell(COLUMNS);
        read_cell(1);
        drain();
    endtask

    // Mostly lines of text ended by newlines, with reads and backspaces mixed in;
    // long lines wrap and the screen keeps scrolling once the bottom is reached.
    task automatic test_random_text(int n_items);
        int sent;
        int len;
        int pick;
        int k;
        int addr;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                len = $urandom_range(0, 20);
            else if (pick < 92)
                len = $urandom_range(70, 90);
            else
                len = $urandom_range(1, 100);
            for (k = 0; k < len && sent < n_items; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 5)
                        addr = cur_row*COLUMNS + cur_col - $urandom_range(0, 3);
                    else if (pick < 9)
                        addr = $urandom_range(0, CELLS - 1);
                    else
                        addr = $urandom_range(CELLS, 2047);
                    read_cell(addr < 0 ? 0 : addr);
                end else if (pick < 30) begin
                    put_char(CODE_BACKSPACE);
                end else begin
                    put_char(CHAR_W'($urandom_range(0, 255)));
                end
                sent++;
            end
            if (sent < n_items && $urandom_range(0, 99) < 85) begin
                put_char(CODE_NEWLINE);
                sent++;
            end
        end
        drain();
    endtask

    // Receiver: when receiver_stalls is set, drops tready for a random gap before taking each result.
    initial begin
        int gap;
        i_m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            gap = receiver_stalls ? $urandom_range(0, 3) : 0;
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_axis_tvalid && i_m_axis_tready));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen_report.cell_data = o_m_axis_tdata[CELL_W-1:0];
            seen_report.row       = o_m_axis_tdata[OUT_ROW_LSB +: ROW_W];
            seen_report.column    = o_m_axis_tdata[OUT_COL_LSB +: COL_W];
            seen_report.scrolled  = o_m_axis_tdata[OUT_SCR_BIT];
            if (awaited_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result cell=%h row=%0d col=%0d scrolled=%0d",
                             $time, seen_report.cell_data, seen_report.row,
                             seen_report.column, seen_report.scrolled);
            end else begin
                want_report = awaited_reports.pop_front();
                if (seen_report.cell_data !== want_report.cell_data
                        || seen_report.row !== want_report.row
                        || seen_report.column !== want_report.column
                        || seen_report.scrolled !== want_report.scrolled) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: mismatch expected cell=%h row=%0d col=%0d scrolled=%0d",
                                 $time, want_report.cell_data, want_report.row,
                                 want_report.column, want_report.scrolled);
                        $display("    actual cell=%h row=%0d col=%0d scrolled=%0d",
                                 seen_report.cell_data, seen_report.row,
                                 seen_report.column, seen_report.scrolled);
                    end
                end
            end
        end
    end

    // Clear pass and scrolls stall the block; the watchdog limit is set to allow for them.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("text_mode_terminal_writer test failed");
            $finish;
        end
    end

    initial begin
        int i;
        int pass;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= OP_PUT;
        i_cfg_valid     <= 1'b0;
        i_cfg_data      <= '0;
        idle_cycles     = 0;
        mismatch_count  = 0;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        for (i = 0; i < CELLS; i++)
            screen_cells[i] = RESET_CELL;
        cur_row    = 0;
        cur_col    = 0;
        text_color = COLOR_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        set_color(8'h00);
        test_control_codes();
        for (pass = 0; pass < 6; pass++) begin
            case (pass)
                0: set_color(8'hFF);
                2: set_color(COLOR_RESET);
                4: set_color(8'h00);
                default: set_color(CHAR_W'($urandom_range(0, 255)));
            endcase
            sender_gaps     = (pass != 1) && (pass != 3);
            receiver_stalls = (pass != 1) && (pass != 2);
            test_random_text(ITEMS_PER_PASS);
        end

        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_reports.size() == 0)
            $display("text_mode_terminal_writer test passed");
        else
            $display("text_mode_terminal_writer test failed");
        $finish;
    end
endmodule
